[rtl/sparse_svm_sgd_update_unit_defines.svh]
// Assertion macros for the sparse SVM SGD update unit checker
`ifndef SPARSE_SVM_SGD_UPDATE_UNIT_DEFINES_SVH
`define SPARSE_SVM_SGD_UPDATE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SSU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SSU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ssu_pkg.sv]
// Shared types and constants of the sparse SVM SGD update unit
`default_nettype none

package ssu_pkg;

	localparam int NUM_FEATURES_DEF     = 65536;
	localparam int MAX_ROW_ELEMENTS_DEF = 256;

	localparam int VALUE_WIDTH = 32;
	localparam int IDX_W       = 16;
	localparam int STEP_W      = 24;
	localparam int THR_W       = 31;
	localparam int CFG_W       = 31;
	localparam int FRAC_W      = 16;

	typedef logic [1:0] op_t;
	localparam op_t OP_TRAIN = 2'd0;
	localparam op_t OP_WRITE = 2'd1;
	localparam op_t OP_READ  = 2'd2;

	typedef logic cfg_idx_t;
	localparam cfg_idx_t REG_STEP = 1'b0;
	localparam cfg_idx_t REG_THR  = 1'b1;

	localparam logic [STEP_W-1:0] STEP_RESET = 24'd655;
	localparam logic [THR_W-1:0]  THR_RESET  = 31'd1000000;

	localparam logic KIND_ROW  = 1'b0;
	localparam logic KIND_READ = 1'b1;

endpackage

`default_nettype wire

[rtl/sparse_svm_sgd_update_unit.sv]
// Sparse linear SVM trainer: row buffer, weight store and one shared multiplier
// Indices go through MOD1 and MOD2 first when NUM_FEATURES is neither a power of two nor >= 65536.
// A weight write or a non-last train element then goes through DISP back to idle; a weight read
// goes through DISP and RDOUT; a row runs a dot pass (D_WRD, D_MUL, D_ACC per element) and, when
// the hinge is active, an update pass (U_WRD, U_WB per element).
// One item in flight; busy stays high until its result. Reset clears control, loads config defaults.
`default_nettype none

module sparse_svm_sgd_update_unit #(
	parameter int NUM_FEATURES     = ssu_pkg::NUM_FEATURES_DEF,
	parameter int MAX_ROW_ELEMENTS = ssu_pkg::MAX_ROW_ELEMENTS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire ssu_pkg::cfg_idx_t                     cfg_index,
	input  wire logic [ssu_pkg::CFG_W-1:0]             cfg_data,
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire ssu_pkg::op_t                          operation,
	input  wire logic [ssu_pkg::IDX_W-1:0]             feature_index,
	input  wire logic signed [ssu_pkg::VALUE_WIDTH-1:0] feature_value,
	input  wire logic                                  label_negative,
	input  wire logic                                  last_element,
	output logic                                       done,
	output logic                                       result_kind,
	output logic signed [ssu_pkg::VALUE_WIDTH-1:0]     margin,
	output logic                                       hinge_active,
	output logic signed [ssu_pkg::VALUE_WIDTH-1:0]     weight_value
);
	import ssu_pkg::*;

	localparam int VW = VALUE_WIDTH;
	localparam int AW = $clog2(NUM_FEATURES);
	localparam int BW = (MAX_ROW_ELEMENTS > 1) ? $clog2(MAX_ROW_ELEMENTS) : 1;
	localparam int CW = $clog2(MAX_ROW_ELEMENTS + 1);
	localparam bit NEED_MOD = (NUM_FEATURES < (1 << IDX_W)) &&
		((NUM_FEATURES & (NUM_FEATURES - 1)) != 0);
	localparam int MOD_K = IDX_W + $clog2(NUM_FEATURES);
	localparam logic [63:0] MOD_M =
		((64'd1 << MOD_K) + 64'(NUM_FEATURES) - 64'd1) / 64'(NUM_FEATURES);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_MOD1  = 4'd1;
	localparam logic [3:0] ST_MOD2  = 4'd2;
	localparam logic [3:0] ST_DISP  = 4'd3;
	localparam logic [3:0] ST_RDOUT = 4'd4;
	localparam logic [3:0] ST_D_RD  = 4'd5;
	localparam logic [3:0] ST_D_WRD = 4'd6;
	localparam logic [3:0] ST_D_MUL = 4'd7;
	localparam logic [3:0] ST_D_ACC = 4'd8;
	localparam logic [3:0] ST_FIN   = 4'd9;
	localparam logic [3:0] ST_U_RD  = 4'd10;
	localparam logic [3:0] ST_U_WRD = 4'd11;
	localparam logic [3:0] ST_U_WB  = 4'd12;

	logic [3:0] state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic [THR_W-1:0] thr_q;
	logic [CW-1:0] cnt_q, elem_q, elem_nx;
	logic more;

	op_t op_q;
	logic [IDX_W-1:0] idx_q;
	logic signed [VW-1:0] val_q;
	logic neg_q, last_q;
	logic [AW-1:0] addr_q;

	logic signed [VW-1:0] mul_a, mul_b;
	logic signed [2*VW-1:0] mul_q;
	logic signed [VW-1:0] dot_q, mg, upd_d;
	logic hinge;

	logic signed [VW-1:0] wt_mem [NUM_FEATURES];
	logic [AW-1:0] bidx_mem [MAX_ROW_ELEMENTS];
	logic signed [VW-1:0] bval_mem [MAX_ROW_ELEMENTS];
	logic signed [VW-1:0] wrd_q, bval_q;
	logic [AW-1:0] bidx_q;

	logic wt_we, wt_re, buf_we, buf_re;
	logic [AW-1:0] wt_waddr, wt_raddr;
	logic signed [VW-1:0] wt_wdata;
	logic [BW-1:0] buf_raddr;

	logic [AW+IDX_W-1:0] idx_ext, rem_ext;
	logic [IDX_W-1:0] rem;

	logic emit, emit_kind, emit_hinge;
	logic signed [VW-1:0] emit_margin, emit_weight;
	logic kind_q, hinge_q;
	logic signed [VW-1:0] margin_q, weight_q;
	logic done_q;

	assign idx_ext = {{AW{1'b0}}, feature_index};
	assign rem     = idx_q - mul_q[IDX_W-1:0];
	assign rem_ext = {{AW{1'b0}}, rem};

	assign elem_nx = elem_q + CW'(1);
	assign more    = elem_nx < cnt_q;
	assign mg      = neg_q ? -dot_q : dot_q;
	assign hinge   = $signed({mg[VW-1], mg}) < $signed({{(VW+1-THR_W){1'b0}}, thr_q});
	assign upd_d   = mul_q[FRAC_W+VW-1:FRAC_W] +
		VW'(mul_q[2*VW-1] & (|mul_q[FRAC_W-1:0]));

	assign busy         = state_q != ST_IDLE;
	assign done         = done_q;
	assign result_kind  = kind_q;
	assign margin       = margin_q;
	assign hinge_active = hinge_q;
	assign weight_value = weight_q;

	always_comb begin
		state_d     = state_q;
		mul_a       = '0;
		mul_b       = '0;
		wt_we       = 1'b0;
		wt_re       = 1'b0;
		wt_waddr    = addr_q;
		wt_raddr    = addr_q;
		wt_wdata    = val_q;
		buf_we      = 1'b0;
		buf_re      = 1'b0;
		buf_raddr   = elem_q[BW-1:0];
		emit        = 1'b0;
		emit_kind   = KIND_ROW;
		emit_margin = '0;
		emit_hinge  = 1'b0;
		emit_weight = '0;
		case (state_q)
			ST_IDLE: begin
				mul_a = VW'(feature_index);
				mul_b = VW'(MOD_M);
				if (start) begin
					state_d = NEED_MOD ? ST_MOD1 : ST_DISP;
				end
			end
			ST_MOD1: begin
				mul_a   = VW'(mul_q[2*VW-1:0] >> MOD_K);
				mul_b   = VW'(NUM_FEATURES);
				state_d = ST_MOD2;
			end
			ST_MOD2: state_d = ST_DISP;
			ST_DISP: begin
				state_d = ST_IDLE;
				case (op_q)
					OP_WRITE: wt_we = 1'b1;
					OP_READ: begin
						wt_re   = 1'b1;
						state_d = ST_RDOUT;
					end
					OP_TRAIN: begin
						buf_we = cnt_q < CW'(MAX_ROW_ELEMENTS);
						if (last_q) begin
							state_d = ST_D_RD;
						end
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_RDOUT: begin
				emit        = 1'b1;
				emit_kind   = KIND_READ;
				emit_weight = wrd_q;
				state_d     = ST_IDLE;
			end
			ST_D_RD: begin
				buf_re  = 1'b1;
				state_d = ST_D_WRD;
			end
			ST_D_WRD: begin
				wt_re    = 1'b1;
				wt_raddr = bidx_q;
				state_d  = ST_D_MUL;
			end
			ST_D_MUL: begin
				mul_a   = bval_q;
				mul_b   = wrd_q;
				state_d = ST_D_ACC;
			end
			ST_D_ACC: begin
				if (more) begin
					buf_re    = 1'b1;
					buf_raddr = elem_nx[BW-1:0];
					state_d   = ST_D_WRD;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (hinge) begin
					state_d = ST_U_RD;
				end else begin
					emit        = 1'b1;
					emit_margin = mg;
					state_d     = ST_IDLE;
				end
			end
			ST_U_RD: begin
				buf_re  = 1'b1;
				state_d = ST_U_WRD;
			end
			ST_U_WRD: begin
				wt_re    = 1'b1;
				wt_raddr = bidx_q;
				mul_a    = bval_q;
				mul_b    = neg_q ? -VW'(step_q) : VW'(step_q);
				state_d  = ST_U_WB;
			end
			ST_U_WB: begin
				wt_we    = 1'b1;
				wt_waddr = bidx_q;
				wt_wdata = wrd_q + upd_d;
				if (more) begin
					buf_re    = 1'b1;
					buf_raddr = elem_nx[BW-1:0];
					state_d   = ST_U_WRD;
				end else begin
					emit        = 1'b1;
					emit_margin = dot_q;
					emit_hinge  = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			elem_q  <= '0;
			done_q  <= 1'b0;
			step_q  <= STEP_RESET;
			thr_q   <= THR_RESET;
		end else begin
			state_q <= state_d;
			done_q  <= emit;
			if (cfg_we) begin
				case (cfg_index)
					REG_STEP: step_q <= cfg_data[STEP_W-1:0];
					REG_THR:  thr_q  <= cfg_data[THR_W-1:0];
					default:  ;
				endcase
			end
			case (state_q)
				ST_DISP: begin
					elem_q <= '0;
					if (buf_we) begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_D_ACC: begin
					if (more) begin
						elem_q <= elem_nx;
					end
				end
				ST_FIN: begin
					elem_q <= '0;
					if (!hinge) begin
						cnt_q <= '0;
					end
				end
				ST_U_WB: begin
					if (more) begin
						elem_q <= elem_nx;
					end else begin
						cnt_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
		if (state_q == ST_IDLE && start) begin
			op_q   <= operation;
			idx_q  <= feature_index;
			val_q  <= feature_value;
			neg_q  <= label_negative;
			last_q <= last_element;
			addr_q <= idx_ext[AW-1:0];
		end
		if (state_q == ST_MOD2) begin
			addr_q <= rem_ext[AW-1:0];
		end
		if (state_q == ST_D_RD) begin
			dot_q <= '0;
		end else if (state_q == ST_D_ACC) begin
			dot_q <= dot_q + mul_q[VW-1:0];
		end else if (state_q == ST_FIN) begin
			dot_q <= mg;
		end
		if (emit) begin
			kind_q   <= emit_kind;
			margin_q <= emit_margin;
			hinge_q  <= emit_hinge;
			weight_q <= emit_weight;
		end
	end

	// weight store: one write, one registered read
	always_ff @(posedge clk) begin
		if (wt_we) begin
			wt_mem[wt_waddr] <= wt_wdata;
		end
		if (wt_re) begin
			wrd_q <= wt_mem[wt_raddr];
		end
	end

	// row buffer
	always_ff @(posedge clk) begin
		if (buf_we) begin
			bidx_mem[cnt_q[BW-1:0]] <= addr_q;
			bval_mem[cnt_q[BW-1:0]] <= val_q;
		end
		if (buf_re) begin
			bidx_q <= bidx_mem[buf_raddr];
			bval_q <= bval_mem[buf_raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/ssu_chk.sv]
// Port-level checker for the sparse SVM SGD update unit, with its bind
`default_nettype none
`include "sparse_svm_sgd_update_unit_defines.svh"

module ssu_chk (
	input wire logic                                   clk,
	input wire logic                                   arst_n,
	input wire logic                                   start,
	input wire logic                                   busy,
	input wire logic                                   done,
	input wire logic                                   result_kind,
	input wire logic signed [ssu_pkg::VALUE_WIDTH-1:0] margin,
	input wire logic                                   hinge_active,
	input wire logic signed [ssu_pkg::VALUE_WIDTH-1:0] weight_value
);
	import ssu_pkg::*;

	`SSU_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
	`SSU_ASSERT_NOW(a_done_after_busy, done, $past(busy), "result without an item in flight")
	`SSU_ASSERT_NEXT(a_single_result, done, !done, "result strobe held over two cycles")
	`SSU_ASSERT_NOW(a_read_fields, done && result_kind == KIND_READ, margin == '0 && !hinge_active, "read word carries row fields")
	`SSU_ASSERT_NOW(a_row_fields, done && result_kind == KIND_ROW, weight_value == '0, "row word carries weight data")

endmodule

bind sparse_svm_sgd_update_unit ssu_chk u_ssu_chk (.*);

`default_nettype wire

[bench/tb_top.sv]
// Self-checking testbench for the sparse SVM SGD update unit
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ssu_pkg::*;

	localparam op_t OP_UNUSED = 2'd3;

	typedef struct {
		logic        kind;
		logic [31:0] mg;
		logic        hinge;
		logic [31:0] wv;
	} outcome_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	cfg_idx_t                      cfg_index = REG_STEP;
	logic [CFG_W-1:0]              cfg_data = '0;
	logic                          start = 1'b0;
	logic                          busy;
	op_t                           operation = OP_TRAIN;
	logic [IDX_W-1:0]              feature_index = '0;
	logic signed [VALUE_WIDTH-1:0] feature_value = '0;
	logic                          label_negative = 1'b0;
	logic                          last_element = 1'b0;
	logic                          done;
	logic                          result_kind;
	logic signed [VALUE_WIDTH-1:0] margin;
	logic                          hinge_active;
	logic signed [VALUE_WIDTH-1:0] weight_value;

	// predictor state
	logic [31:0]       w_mirror [NUM_FEATURES_DEF];
	bit                w_known [NUM_FEATURES_DEF];
	logic [IDX_W-1:0]  known_addrs [$];
	logic [IDX_W-1:0]  row_idx_q [$];
	logic [31:0]       row_val_q [$];
	logic [STEP_W-1:0] step_cfg = STEP_RESET;
	logic [THR_W-1:0]  thr_cfg = THR_RESET;
	outcome_t          outcome_q [$];

	int mismatches = 0;
	int words_sent = 0;
	bit calm = 1'b0;

	sparse_svm_sgd_update_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.start          (start),
		.busy           (busy),
		.operation      (operation),
		.feature_index  (feature_index),
		.feature_value  (feature_value),
		.label_negative (label_negative),
		.last_element   (last_element),
		.done           (done),
		.result_kind    (result_kind),
		.margin         (margin),
		.hinge_active   (hinge_active),
		.weight_value   (weight_value)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		if (mismatches <= 200)
			$display("%0t mismatch %s: got %h, expected %h", $time, what, got, want);
	endtask

	// predicted effect of each accepted word, including the SGD step when a row ends
	task automatic sgd_apply(op_t op, logic [IDX_W-1:0] idx, logic [31:0] val,
			logic neg, logic last);
		outcome_t o;
		logic [31:0] dot;
		longint delta;
		o.kind = KIND_ROW;
		o.mg = '0;
		o.hinge = 1'b0;
		o.wv = '0;
		dot = '0;
		case (op)
			OP_WRITE: begin
				w_mirror[idx] = val;
				if (!w_known[idx]) begin
					w_known[idx] = 1'b1;
					known_addrs.push_back(idx);
				end
			end
			OP_READ: begin
				o.kind = KIND_READ;
				o.wv = w_mirror[idx];
				outcome_q.push_back(o);
			end
			OP_TRAIN: begin
				if (row_idx_q.size() < MAX_ROW_ELEMENTS_DEF) begin
					row_idx_q.push_back(idx);
					row_val_q.push_back(val);
				end
				if (last) begin
					foreach (row_idx_q[i])
						dot = dot + row_val_q[i] * w_mirror[row_idx_q[i]];
					o.mg = neg ? -dot : dot;
					o.hinge = longint'($signed(o.mg)) < longint'(thr_cfg);
					if (o.hinge) begin
						foreach (row_idx_q[i]) begin
							delta = longint'($signed(row_val_q[i])) * longint'(step_cfg);
							if (neg)
								delta = -delta;
							delta = delta / 65536;
							w_mirror[row_idx_q[i]] = w_mirror[row_idx_q[i]] + delta[31:0];
						end
					end
					row_idx_q.delete();
					row_val_q.delete();
					outcome_q.push_back(o);
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk) begin : check_result
		outcome_t want;
		if (arst_n && done) begin
			if (outcome_q.size() == 0) begin
				report_mismatch("result with nothing pending", {31'b0, result_kind}, '0);
			end else begin
				want = outcome_q.pop_front();
				if (result_kind !== want.kind)
					report_mismatch("result_kind", {31'b0, result_kind}, {31'b0, want.kind});
				if (margin !== want.mg)
					report_mismatch("margin", margin, want.mg);
				if (hinge_active !== want.hinge)
					report_mismatch("hinge_active", {31'b0, hinge_active}, {31'b0, want.hinge});
				if (weight_value !== want.wv)
					report_mismatch("weight_value", weight_value, want.wv);
			end
		end
	end

	task automatic send_word(op_t op, logic [IDX_W-1:0] idx, logic [31:0] val,
			logic neg, logic last);
		if (!calm && $urandom_range(0, 99) < 33) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		start <= 1'b1;
		operation <= op;
		feature_index <= idx;
		feature_value <= val;
		label_negative <= neg;
		last_element <= last;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sgd_apply(op, idx, val, neg, last);
		if (op != OP_UNUSED)
			words_sent++;
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (outcome_q.size() != 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_STEP)
			step_cfg = data[STEP_W-1:0];
		else
			thr_cfg = data[THR_W-1:0];
		@(posedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 4000) - 2000;
			1: return $urandom();
			2: case ($urandom_range(0, 3))
				0: return 32'h8000_0000;
				1: return 32'h7FFF_FFFF;
				2: return 32'h0000_0000;
				default: return 32'hFFFF_FFFF;
			endcase
			default: return $urandom_range(0, 1 << 21) - (1 << 20);
		endcase
	endfunction

	function automatic logic [IDX_W-1:0] pick_known();
		return known_addrs[$urandom_range(0, known_addrs.size() - 1)];
	endfunction

	task automatic send_noise();
		case ($urandom_range(0, 3))
			0: send_word(OP_WRITE, IDX_W'($urandom()), pick_value(), 1'($urandom()),
					1'($urandom()));
			1: send_word(OP_WRITE, pick_known(), pick_value(), 1'($urandom()),
					1'($urandom()));
			2: send_word(OP_READ, pick_known(), $urandom(), 1'($urandom()), 1'($urandom()));
			default: send_word(OP_UNUSED, IDX_W'($urandom()), $urandom(), 1'($urandom()),
					1'($urandom()));
		endcase
	endtask

	task automatic send_row(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 8)
				send_noise();
			send_word(OP_TRAIN, pick_known(), pick_value(), 1'($urandom()), i == n - 1);
		end
	endtask

	task automatic run_random(int n_words, logic [STEP_W-1:0] step, logic [THR_W-1:0] thr);
		int stop_at;
		int pick;
		wait_idle();
		write_reg(REG_STEP, {{(CFG_W-STEP_W){1'b0}}, step});
		write_reg(REG_THR, thr);
		stop_at = words_sent + n_words;
		while (words_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 72)
				send_row($urandom_range(0, 99) < 85 ? $urandom_range(1, 6)
						: $urandom_range(7, 40));
			else
				send_noise();
		end
	endtask

	// reset settings, extremes of the fields, every operation and the corner cases
	task automatic test_basics();
		send_word(OP_WRITE, 16'h0000, 32'h7FFF_FFFF, 1'b0, 1'b0);
		send_word(OP_WRITE, 16'hFFFF, 32'h8000_0000, 1'b1, 1'b1);
		send_word(OP_WRITE, 16'h1234, 32'h0000_0000, 1'b0, 1'b0);
		send_word(OP_WRITE, 16'hA5A5, 32'hFFFF_FFFF, 1'b0, 1'b0);
		send_word(OP_WRITE, 16'h5A5A, 32'h0000_0001, 1'b0, 1'b0);
		send_word(OP_READ, 16'h0000, '0, 1'b0, 1'b0);
		send_word(OP_READ, 16'hFFFF, '0, 1'b1, 1'b1);
		send_word(OP_READ, 16'h1234, '0, 1'b0, 1'b0);
		send_word(OP_READ, 16'hA5A5, '0, 1'b0, 1'b0);
		send_word(OP_READ, 16'h5A5A, '0, 1'b0, 1'b0);
		send_word(OP_UNUSED, 16'h5A5A, 32'hDEAD_BEEF, 1'b1, 1'b1);
		send_word(OP_TRAIN, 16'h5A5A, 32'd1000, 1'b0, 1'b1);
		// label from last element, repeated index
		send_word(OP_TRAIN, 16'h1234, 32'd5, 1'b1, 1'b0);
		send_word(OP_TRAIN, 16'h5A5A, -32'sd7, 1'b0, 1'b0);
		send_word(OP_TRAIN, 16'h5A5A, 32'd3, 1'b1, 1'b1);
		// read and write served in the middle of a row
		send_word(OP_TRAIN, 16'hA5A5, 32'd100, 1'b0, 1'b0);
		send_word(OP_READ, 16'h5A5A, '0, 1'b0, 1'b0);
		send_word(OP_WRITE, 16'h1234, 32'd2, 1'b0, 1'b0);
		send_word(OP_TRAIN, 16'h1234, 32'd50, 1'b0, 1'b1);
		// margin equal to the threshold, then just below
		send_word(OP_WRITE, 16'h0F0F, 32'd1, 1'b0, 1'b0);
		send_word(OP_TRAIN, 16'h0F0F, 32'd1000000, 1'b0, 1'b1);
		send_word(OP_TRAIN, 16'h0F0F, 32'd999999, 1'b0, 1'b1);
		send_word(OP_READ, 16'h0F0F, '0, 1'b0, 1'b0);
		send_word(OP_TRAIN, 16'h0000, 32'h8000_0000, 1'b1, 1'b1);
		send_word(OP_READ, 16'h0000, '0, 1'b0, 1'b0);
	endtask

	// more elements than the row buffer holds, then a short row
	task automatic test_row_overflow();
		send_row(MAX_ROW_ELEMENTS_DEF + 2);
		send_row(3);
	endtask

	task automatic test_extreme_settings();
		run_random(310, 24'hFF_FFFF, 31'd0);
		run_random(310, 24'd0, 31'h7FFF_FFFF);
	endtask

	task automatic test_back_to_back();
		calm = 1'b1;
		run_random(310, STEP_W'($urandom_range(0, 24'hFF_FFFF)),
				THR_W'($urandom_range(0, 31'h7FFF_FFFF)));
		calm = 1'b0;
	endtask

	task automatic test_mixed_settings();
		run_random(310, 24'd65536, THR_RESET);
		run_random(310, STEP_W'($urandom_range(0, 1 << 17)),
				THR_W'($urandom_range(0, 1 << 24)));
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basics();
		test_row_overflow();
		test_extreme_settings();
		test_back_to_back();
		test_mixed_settings();
		wait_idle();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire
